// ----- hw/rtl/median_filter_3x3_clipped_assert.svh -----
// Assertion macros shared by the median filter design.
`ifndef MEDIAN_FILTER_3X3_CLIPPED_ASSERT_SVH
`define MEDIAN_FILTER_3X3_CLIPPED_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define MF3_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define MF3_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/mf3_pkg.sv -----
package mf3_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW = $clog2(MAX_WIDTH + 1);
   localparam int WID_W = 11;
   localparam int HGT_W = 16;
   localparam int CSR_W = 16;
   localparam int PIX_W = 8;
   localparam int ROW_SLOTS = 4;
   localparam int SLOT_W = 2;
   localparam int WIN_SIDE = 3;
   localparam int WIN = WIN_SIDE * WIN_SIDE;
   localparam int CNT_W = $clog2(WIN + 1);
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic {
      MODE_PIXEL = 1'b0,
      MODE_DRAIN = 1'b1
   } mode_type;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_reg_type;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [WIN_SIDE-1:0][PIX_W-1:0] col_type;

   typedef struct packed {
      mode_type mode;
      pix_type  pixel;
   } req_type;

   typedef struct packed {
      pix_type median;
      logic    last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic    first;
      logic    top_ok;
      logic    bot_ok;
      logic    right_ok;
      logic    last;
      col_type col_a;
      col_type col_b;
   } cmd_type;

   typedef struct packed {
      logic                 empty;
      logic [CMD_CNT_W-1:0] count;
   } qstat_type;

endpackage

// ----- hw/rtl/mf3_ram.sv -----
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- hw/rtl/mf3_front.sv -----
module mf3_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  mf3_pkg::csr_reg_type       csr_index,
   input  logic [mf3_pkg::CSR_W-1:0]  csr_wdata,
   input  logic                       req_push,
   input  mf3_pkg::req_type           req_data,
   output logic                       req_full,
   input  mf3_pkg::qstat_type         q_stat,
   output logic                       cmd_push,
   output mf3_pkg::cmd_type           cmd_data
);

   localparam int COL_W = mf3_pkg::COL_W;
   localparam int EW = mf3_pkg::EW;
   localparam int HGT_W = mf3_pkg::HGT_W;
   localparam int WID_W = mf3_pkg::WID_W;
   localparam int SLOT_W = mf3_pkg::SLOT_W;

   logic [WID_W-1:0] width_ff, width_in;
   logic [HGT_W-1:0] height_ff, height_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [HGT_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [HGT_W-1:0] out_row_ff, out_row_in;
   logic             done_ff, done_in;
   logic             f1_valid_ff;

   logic [SLOT_W-1:0] f1_slot_ff;
   logic              f1_top_ff;
   logic              f1_bot_ff;
   logic              f1_first_ff;
   logic              f1_right_ff;
   logic              f1_last_ff;
   logic              byp_en_ff;
   logic [SLOT_W-1:0] byp_slot_ff;
   logic [COL_W-1:0]  byp_col_ff;
   mf3_pkg::pix_type  byp_data_ff;
   logic [COL_W-1:0]  addr_a_ff;

   logic [EW-1:0]    eff_w;
   logic [HGT_W:0]   eff_h;
   logic             accept;
   logic             wr;
   logic [EW-1:0]    col_inc;
   logic [HGT_W:0]   row_inc;
   logic [EW-1:0]    o_col_inc;
   logic [HGT_W:0]   o_row_inc;
   logic [HGT_W:0]   r1;
   logic [EW-1:0]    c1;
   logic             ready;
   logic             issue;
   logic             last;
   logic [COL_W-1:0] addr_a;

   mf3_pkg::pix_type ram_a [mf3_pkg::ROW_SLOTS];
   mf3_pkg::pix_type ram_b [mf3_pkg::ROW_SLOTS];
   mf3_pkg::pix_type dat_a [mf3_pkg::ROW_SLOTS];
   mf3_pkg::pix_type dat_b [mf3_pkg::ROW_SLOTS];
   logic [SLOT_W-1:0] top_slot;
   logic [SLOT_W-1:0] bot_slot;

   assign req_full = (int'(q_stat.count) + int'(f1_valid_ff)) >= mf3_pkg::CMD_DEPTH;
   assign accept = req_push && !req_full;
   assign wr = accept && (req_data.mode == mf3_pkg::MODE_PIXEL) && !done_ff;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = EW'(1);
      end else if (32'(width_ff) > 32'(mf3_pkg::MAX_WIDTH)) begin
         eff_w = EW'(mf3_pkg::MAX_WIDTH);
      end else begin
         eff_w = EW'(width_ff);
      end
      eff_h = (height_ff == '0) ? (HGT_W+1)'(1) : {1'b0, height_ff};
   end

   assign col_inc = EW'(in_col_ff) + EW'(1);
   assign row_inc = {1'b0, in_row_ff} + (HGT_W+1)'(1);
   assign o_col_inc = EW'(out_col_ff) + EW'(1);
   assign o_row_inc = {1'b0, out_row_ff} + (HGT_W+1)'(1);
   assign r1 = (o_row_inc < eff_h) ? o_row_inc : eff_h - (HGT_W+1)'(1);
   assign c1 = (o_col_inc < eff_w) ? o_col_inc : eff_w - EW'(1);
   assign last = (o_col_inc >= eff_w) && (o_row_inc >= eff_h);
   assign addr_a = (out_col_ff == '0) ? '0 : o_col_inc[COL_W-1:0];

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      done_in = done_ff;
      if (wr) begin
         if (col_inc >= eff_w) begin
            in_col_in = '0;
            in_row_in = row_inc[HGT_W-1:0];
            if (row_inc >= eff_h) begin
               done_in = 1'b1;
            end
         end else begin
            in_col_in = col_inc[COL_W-1:0];
         end
      end
      ready = done_in || ({1'b0, in_row_in} > r1) ||
              (({1'b0, in_row_in} == r1) && (EW'(in_col_in) > c1));
      issue = accept && ready;
      if (issue) begin
         if (o_col_inc >= eff_w) begin
            out_col_in = '0;
            out_row_in = o_row_inc[HGT_W-1:0];
         end else begin
            out_col_in = o_col_inc[COL_W-1:0];
         end
         if (last) begin
            in_col_in = '0;
            in_row_in = '0;
            out_col_in = '0;
            out_row_in = '0;
            done_in = 1'b0;
         end
      end
      if (csr_we) begin
         unique case (csr_index)
            mf3_pkg::REG_IMAGE_WIDTH: width_in = csr_wdata[WID_W-1:0];
            mf3_pkg::REG_IMAGE_HEIGHT: height_in = csr_wdata[HGT_W-1:0];
            default: width_in = width_ff;
         endcase
         in_col_in = '0;
         in_row_in = '0;
         out_col_in = '0;
         out_row_in = '0;
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WID_W'(1024);
         height_ff <= HGT_W'(480);
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         done_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         done_ff <= done_in;
         f1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      f1_slot_ff <= out_row_ff[SLOT_W-1:0];
      f1_top_ff <= (out_row_ff != '0);
      f1_bot_ff <= (o_row_inc < eff_h);
      f1_first_ff <= (out_col_ff == '0);
      f1_right_ff <= (o_col_inc < eff_w);
      f1_last_ff <= last;
      byp_en_ff <= wr;
      byp_slot_ff <= in_row_ff[SLOT_W-1:0];
      byp_col_ff <= in_col_ff;
      byp_data_ff <= req_data.pixel;
      addr_a_ff <= addr_a;
   end

   for (genvar s = 0; s < mf3_pkg::ROW_SLOTS; s++) begin : g_slot
      mf3_ram #(
         .WIDTH(mf3_pkg::PIX_W),
         .DEPTH(mf3_pkg::MAX_WIDTH)
      ) u_ram (
         .clock(clock),
         .wr_en(wr && (in_row_ff[SLOT_W-1:0] == SLOT_W'(s))),
         .wr_addr(in_col_ff),
         .wr_data(req_data.pixel),
         .rd_addr_a(addr_a),
         .rd_data_a(ram_a[s]),
         .rd_addr_b(COL_W'(1)),
         .rd_data_b(ram_b[s])
      );
   end

   // A pixel written at the same edge as the read is taken from the bypass.
   always_comb begin
      for (int s = 0; s < mf3_pkg::ROW_SLOTS; s++) begin
         dat_a[s] = (byp_en_ff && (byp_slot_ff == SLOT_W'(s)) && (byp_col_ff == addr_a_ff)) ?
                    byp_data_ff : ram_a[s];
         dat_b[s] = (byp_en_ff && (byp_slot_ff == SLOT_W'(s)) && (byp_col_ff == COL_W'(1))) ?
                    byp_data_ff : ram_b[s];
      end
   end

   assign top_slot = f1_slot_ff - SLOT_W'(1);
   assign bot_slot = f1_slot_ff + SLOT_W'(1);

   always_comb begin
      cmd_data.first = f1_first_ff;
      cmd_data.top_ok = f1_top_ff;
      cmd_data.bot_ok = f1_bot_ff;
      cmd_data.right_ok = f1_right_ff;
      cmd_data.last = f1_last_ff;
      cmd_data.col_a[0] = dat_a[top_slot];
      cmd_data.col_a[1] = dat_a[f1_slot_ff];
      cmd_data.col_a[2] = dat_a[bot_slot];
      cmd_data.col_b[0] = dat_b[top_slot];
      cmd_data.col_b[1] = dat_b[f1_slot_ff];
      cmd_data.col_b[2] = dat_b[bot_slot];
   end

   assign cmd_push = f1_valid_ff;

endmodule

// ----- hw/rtl/mf3_cmd_queue.sv -----
module mf3_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mf3_pkg::cmd_type   push_data,
   input  logic               pop,
   output mf3_pkg::cmd_type   pop_data,
   output mf3_pkg::qstat_type stat
);

   localparam int PTR_W = mf3_pkg::CMD_PTR_W;
   localparam int CNT_W = mf3_pkg::CMD_CNT_W;

   mf3_pkg::cmd_type entry_ff [mf3_pkg::CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.empty = (count_ff == '0);

endmodule

// ----- hw/rtl/mf3_back.sv -----
module mf3_back (
   input  logic               clock,
   input  logic               reset,
   input  mf3_pkg::qstat_type q_stat,
   input  mf3_pkg::cmd_type   cmd_data,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output mf3_pkg::rsp_type   rsp_data
);

   localparam int WIN = mf3_pkg::WIN;
   localparam int CNT_W = mf3_pkg::CNT_W;
   localparam int PTR_W = mf3_pkg::OUT_PTR_W;
   localparam int OCNT_W = mf3_pkg::OUT_CNT_W;

   mf3_pkg::col_type col_l_ff, col_m_ff, col_r_ff;
   logic lv_ff, rv_ff, top_ff, bot_ff, last1_ff;
   logic b1_valid_ff;

   mf3_pkg::pix_type vals [WIN];
   logic [WIN-1:0] vld;
   logic [WIN-1:0] less [WIN];
   logic [2:0] row_ok;

   logic [WIN-1:0]   less_ff [WIN];
   mf3_pkg::pix_type vals_ff [WIN];
   logic [WIN-1:0]   vld_ff;
   logic [CNT_W-1:0] tgt_ff;
   logic             last2_ff;
   logic             b2_valid_ff;

   mf3_pkg::pix_type med;

   mf3_pkg::rsp_type out_ff [mf3_pkg::OUT_DEPTH];
   logic [PTR_W-1:0]  owr_ptr_ff, owr_ptr_in;
   logic [PTR_W-1:0]  ord_ptr_ff, ord_ptr_in;
   logic [OCNT_W-1:0] ocount_ff, ocount_in;
   logic              out_pop;

   assign q_pop = !q_stat.empty &&
                  ((int'(ocount_ff) + int'(b1_valid_ff) + int'(b2_valid_ff)) <
                   mf3_pkg::OUT_DEPTH);

   // The window slides one column per item and restarts at the first column of a row.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         if (cmd_data.first) begin
            lv_ff <= 1'b0;
            col_m_ff <= cmd_data.col_a;
            col_r_ff <= cmd_data.col_b;
         end else begin
            lv_ff <= 1'b1;
            col_l_ff <= col_m_ff;
            col_m_ff <= col_r_ff;
            col_r_ff <= cmd_data.col_a;
         end
         rv_ff <= cmd_data.right_ok;
         top_ff <= cmd_data.top_ok;
         bot_ff <= cmd_data.bot_ok;
         last1_ff <= cmd_data.last;
      end
   end

   assign row_ok = {bot_ff, 1'b1, top_ff};

   always_comb begin
      for (int r = 0; r < mf3_pkg::WIN_SIDE; r++) begin
         vals[r] = col_l_ff[r];
         vals[r + 3] = col_m_ff[r];
         vals[r + 6] = col_r_ff[r];
         vld[r] = lv_ff && row_ok[r];
         vld[r + 3] = row_ok[r];
         vld[r + 6] = rv_ff && row_ok[r];
      end
      for (int i = 0; i < WIN; i++) begin
         for (int j = 0; j < WIN; j++) begin
            less[i][j] = vld[j] && ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WIN; i++) begin
         less_ff[i] <= less[i];
         vals_ff[i] <= vals[i];
      end
      vld_ff <= vld;
      tgt_ff <= CNT_W'($countones(vld)) >> 1;
      last2_ff <= last1_ff;
   end

   // Each valid pixel has a distinct rank, so exactly one matches the target.
   always_comb begin
      med = '0;
      for (int i = 0; i < WIN; i++) begin
         if (vld_ff[i] && (CNT_W'($countones(less_ff[i])) == tgt_ff)) begin
            med = med | vals_ff[i];
         end
      end
   end

   assign out_pop = rsp_pop && !rsp_empty;

   always_comb begin
      owr_ptr_in = owr_ptr_ff;
      ord_ptr_in = ord_ptr_ff;
      ocount_in = ocount_ff;
      if (b2_valid_ff) begin
         owr_ptr_in = owr_ptr_ff + PTR_W'(1);
      end
      if (out_pop) begin
         ord_ptr_in = ord_ptr_ff + PTR_W'(1);
      end
      if (b2_valid_ff && !out_pop) begin
         ocount_in = ocount_ff + OCNT_W'(1);
      end else if (out_pop && !b2_valid_ff) begin
         ocount_in = ocount_ff - OCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         owr_ptr_ff <= '0;
         ord_ptr_ff <= '0;
         ocount_ff <= '0;
      end else begin
         b1_valid_ff <= q_pop;
         b2_valid_ff <= b1_valid_ff;
         owr_ptr_ff <= owr_ptr_in;
         ord_ptr_ff <= ord_ptr_in;
         ocount_ff <= ocount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b2_valid_ff) begin
         out_ff[owr_ptr_ff] <= '{median: med, last_of_frame: last2_ff};
      end
   end

   assign rsp_empty = (ocount_ff == '0);
   assign rsp_data = out_ff[ord_ptr_ff];

endmodule

// ----- hw/rtl/median_filter_3x3_clipped.sv -----
// Streaming 3x3 median filter for 8-bit pixels in raster order, one item per clock
// sustained while req_full stays low. Each result is the median of the pixel's 3x3
// neighborhood clipped to the image, taking the upper middle value when the count of
// pixels is even. A result leaves once its window has arrived, about one row plus one
// pixel after its own pixel; after the last pixel, drain items push the remaining
// results out, and a pixel item sent while results are still pending counts as a drain
// item. An accepted item reaches its result through row store read, command queue,
// window, rank compare and result queue. Rows are held in four row stores of
// MAX_WIDTH pixels with one write and two read ports each, which is what allows the two
// columns needed at the start of a row to be fetched together. Writing either
// configuration register restarts the frame; width 0 acts as 1 and widths beyond 1024
// act as 1024, height 0 acts as 1. The row stores need no clearing after reset.
`include "median_filter_3x3_clipped_assert.svh"

module median_filter_3x3_clipped (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  mf3_pkg::csr_reg_type      csr_index,
   input  logic [mf3_pkg::CSR_W-1:0] csr_wdata,
   input  logic                      req_push,
   input  mf3_pkg::req_type          req_data,
   output logic                      req_full,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output mf3_pkg::rsp_type          rsp_data
);

   mf3_pkg::qstat_type q_stat;
   mf3_pkg::cmd_type   cmd_wr;
   mf3_pkg::cmd_type   cmd_rd;
   logic               cmd_push;
   logic               q_pop;

   mf3_front u_front (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_push(req_push),
      .req_data(req_data),
      .req_full(req_full),
      .q_stat(q_stat),
      .cmd_push(cmd_push),
      .cmd_data(cmd_wr)
   );

   mf3_cmd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(cmd_push),
      .push_data(cmd_wr),
      .pop(q_pop),
      .pop_data(cmd_rd),
      .stat(q_stat)
   );

   mf3_back u_back (
      .clock(clock),
      .reset(reset),
      .q_stat(q_stat),
      .cmd_data(cmd_rd),
      .q_pop(q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

   `MF3_ASSERT_ALWAYS(a_queue_bound, clock, reset, q_stat.count <= mf3_pkg::CMD_DEPTH, "command queue over depth")
   `MF3_ASSERT_IMPLIES(a_queue_no_overflow, clock, reset, cmd_push, (q_stat.count < mf3_pkg::CMD_DEPTH) || q_pop, "command pushed into full queue")
   `MF3_ASSERT_IMPLIES(a_queue_no_underflow, clock, reset, q_pop, !q_stat.empty, "command popped from empty queue")

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

import mf3_pkg::*;

class median_board;
   pix_type     rows[ROW_SLOTS][MAX_WIDTH];
   int unsigned wid_reg = 1024;
   int unsigned hgt_reg = 480;
   int unsigned in_col, in_row, out_col, out_row;
   bit          in_done;
   rsp_type     medians_due[$];
   int          fails;

   function void restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      in_done = 0;
   endfunction

   function int unsigned eff_w();
      if (wid_reg == 0) return 1;
      if (wid_reg > MAX_WIDTH) return MAX_WIDTH;
      return wid_reg;
   endfunction

   function int unsigned eff_h();
      return (hgt_reg == 0) ? 1 : hgt_reg;
   endfunction

   function void note_write(csr_reg_type idx, logic [CSR_W-1:0] val);
      if (idx == REG_IMAGE_WIDTH) wid_reg = 32'(val & 16'h07FF);
      else hgt_reg = 32'(val);
      restart();
   endfunction

   function void note_item(req_type it);
      int unsigned w, h, r0, r1, c0, c1, n, rr, cc, i, j;
      pix_type     vals[WIN];
      pix_type     tmp;
      bit          last;
      rsp_type     res;
      w = eff_w();
      h = eff_h();
      if (it.mode == MODE_PIXEL && !in_done) begin
         rows[in_row % ROW_SLOTS][in_col] = it.pixel;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) in_done = 1;
         end
      end
      r0 = (out_row > 0) ? out_row - 1 : out_row;
      r1 = (out_row + 1 < h) ? out_row + 1 : h - 1;
      c0 = (out_col > 0) ? out_col - 1 : out_col;
      c1 = (out_col + 1 < w) ? out_col + 1 : w - 1;
      if (!(in_done || in_row > r1 || (in_row == r1 && in_col > c1))) return;
      n = 0;
      for (rr = r0; rr <= r1; rr++) begin
         for (cc = c0; cc <= c1; cc++) begin
            vals[n] = rows[rr % ROW_SLOTS][cc];
            n++;
         end
      end
      for (i = 0; i < n; i++) begin
         for (j = 0; j + 1 < n - i; j++) begin
            if (vals[j] > vals[j+1]) begin
               tmp = vals[j];
               vals[j] = vals[j+1];
               vals[j+1] = tmp;
            end
         end
      end
      out_col++;
      last = 0;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) last = 1;
      end
      res.median = vals[n >> 1];
      res.last_of_frame = last;
      medians_due.push_back(res);
      if (last) restart();
   endfunction

   function void check(rsp_type got);
      rsp_type want;
      if (medians_due.size() == 0) begin
         $error("unexpected result: median %0d last_of_frame %0d",
                got.median, got.last_of_frame);
         fails++;
         return;
      end
      want = medians_due.pop_front();
      if (got.median !== want.median) begin
         $error("median: expected %0d, actual %0d", want.median, got.median);
         fails++;
      end
      if (got.last_of_frame !== want.last_of_frame) begin
         $error("last_of_frame: expected %0d, actual %0d",
                want.last_of_frame, got.last_of_frame);
         fails++;
      end
   endfunction
endclass

module testbench;
   localparam int LIMIT = 800000;
   localparam int SETTLE = 20;

   logic              clock;
   logic              reset;
   logic              csr_we;
   csr_reg_type       csr_index;
   logic [CSR_W-1:0]  csr_wdata;
   logic              req_push;
   req_type           req_data;
   logic              req_full;
   logic              rsp_empty;
   logic              rsp_pop;
   rsp_type           rsp_data;

   median_board board = new();
   int  cycles;
   int  items_sent;
   int  pop_wait;
   bit  fast;

   median_filter_3x3_clipped i_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("median_filter_3x3_clipped verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            board.check(rsp_data);
            pop_wait = fast ? 0 : $urandom_range(0, 8);
         end
         if (pop_wait > 0) begin
            pop_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic send(req_type it);
      int gap;
      gap = fast ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_full);
      board.note_item(it);
      items_sent++;
   endtask

   function automatic pix_type pick_pixel();
      if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return pix_type'($urandom_range(0, 255));
   endfunction

   task automatic send_pixel(pix_type v);
      req_type it;
      it.mode = MODE_PIXEL;
      it.pixel = v;
      send(it);
   endtask

   task automatic send_drain();
      req_type it;
      it.mode = MODE_DRAIN;
      it.pixel = pix_type'($urandom_range(0, 255));
      send(it);
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (board.medians_due.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      board.note_write(idx, val);
      @(posedge clock);
   endtask

   task automatic run_frame(int stop_at, bit noisy);
      int total;
      int k;
      total = board.eff_w() * board.eff_h();
      for (k = 0; k < total && k < stop_at; k++) begin
         if (noisy && $urandom_range(0, 9) == 0) send_drain();
         send_pixel(pick_pixel());
      end
      if (k < total) return;
      while (board.in_done) begin
         if ($urandom_range(0, 4) == 0) send_pixel(pick_pixel());
         else send_drain();
      end
   endtask

   initial begin
      int k;
      int stop_at;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= REG_IMAGE_WIDTH;
      csr_wdata <= '0;
      req_push <= 1'b0;
      req_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pixel(8'h00);
      send_drain();
      send_pixel(8'hFF);
      settle();

      write_reg(REG_IMAGE_WIDTH, 16'd3);
      write_reg(REG_IMAGE_HEIGHT, 16'd3);
      for (k = 0; k < 5; k++) send_pixel((k % 2) ? 8'hFF : 8'h00);
      settle();
      for (k = 5; k < 9; k++) send_pixel(pix_type'(k * 30));
      send_pixel(8'h80);
      while (board.in_done) send_drain();
      send_drain();
      settle();

      write_reg(REG_IMAGE_WIDTH, 16'hF800);
      write_reg(REG_IMAGE_HEIGHT, 16'd0);
      send_pixel(8'hA5);
      settle();

      write_reg(REG_IMAGE_WIDTH, 16'd2);
      write_reg(REG_IMAGE_HEIGHT, 16'd2);
      run_frame(4, 0);
      settle();

      write_reg(REG_IMAGE_WIDTH, 16'd2047);
      write_reg(REG_IMAGE_HEIGHT, 16'd1);
      run_frame(12, 0);
      settle();
      write_reg(REG_IMAGE_WIDTH, 16'd1024);
      write_reg(REG_IMAGE_HEIGHT, 16'd65535);
      run_frame(10, 0);
      settle();
      write_reg(REG_IMAGE_WIDTH, 16'd1);
      write_reg(REG_IMAGE_HEIGHT, 16'd5);
      run_frame(5, 0);
      settle();

      items_sent = 0;
      while (items_sent < 1650) begin
         fast = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) != 0 || board.eff_w() > 40) begin
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0) k = 0;
            write_reg(REG_IMAGE_WIDTH, CSR_W'(k | ($urandom_range(0, 31) << 11)));
         end
         if ($urandom_range(0, 2) != 0 || board.eff_h() > 8) begin
            write_reg(REG_IMAGE_HEIGHT, CSR_W'($urandom_range(0, 6)));
         end
         stop_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60) : 1 << 30;
         run_frame(stop_at, 1);
         if ($urandom_range(0, 1) != 0) run_frame(1 << 30, 1);
         settle();
      end
      fast = 0;

      settle();
      if (board.fails == 0) begin
         $display("median_filter_3x3_clipped verification clean");
      end else begin
         $display("median_filter_3x3_clipped verification failed");
      end
      $finish;
   end
endmodule
